@@ src/spm_pkg.sv @@
// Shared types, constants and float helpers for the softened point-mass unit.
// Used by every module under src except spm_dly; no dependencies of its own.
package spm_pkg;

  typedef struct packed {
    logic               sgn;
    logic signed [11:0] e;     // biased exponent after normalization
    logic [23:0]        m;     // mantissa, leading one at bit 23 unless zero
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  typedef struct packed {
    logic sgn;
    logic nan;
    logic inf;
    logic zero;
  } fp_flag_t;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] F_HALF    = 32'h3F00_0000;
  localparam logic [31:0] F_THREE   = 32'h4040_0000;
  localparam logic [31:0] F_FIVE    = 32'h40A0_0000;
  localparam logic [31:0] F_SEVEN   = 32'h40E0_0000;

  localparam logic [1:0] REG_MASS   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_KERNEL = 2'd2;

  localparam logic [1:0] KORD_PLAIN = 2'd0;
  localparam logic [1:0] KORD_ONE   = 2'd1;
  localparam logic [1:0] KORD_TWO   = 2'd2;
  localparam logic [1:0] KORD_THREE = 2'd3;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  function automatic fp_unp_t fp_unpack(input logic [31:0] b);
    fp_unp_t    u;
    logic [4:0] lz;
    u.sgn  = b[31];
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.zero = (b[30:0] == 31'd0);
    lz     = lzc24({1'b0, b[22:0]});
    if (b[30:23] != 8'd0) begin
      u.m = {1'b1, b[22:0]};
      u.e = $signed({4'd0, b[30:23]});
    end else begin
      u.m = {1'b0, b[22:0]} << lz;
      u.e = 12'sd1 - $signed({7'd0, lz});
    end
    return u;
  endfunction

  // sig: leading one at bit 26, bits [2:0] are guard, round and sticky.
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [26:0] sig);
    logic [63:0]        wide;
    logic [26:0]        sg;
    logic [7:0]         ef;
    logic signed [11:0] shv;
    logic [4:0]         sh;
    logic               inc;
    logic [30:0]        mag;
    sg = sig;
    ef = 8'd0;
    if (e >= 12'sd255) return {s, 8'hFF, 23'd0};
    if (e <= 12'sd0) begin
      shv  = 12'sd1 - e;
      sh   = (shv > 12'sd31) ? 5'd31 : shv[4:0];
      wide = {sig, 37'd0} >> sh;
      sg   = {wide[63:38], wide[37] | (|wide[36:0])};
    end else begin
      ef = e[7:0];
    end
    inc = sg[2] & (sg[1] | sg[0] | sg[3]);
    mag = {ef, sg[25:3]} + {30'd0, inc};
    return {s, mag};
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] b);
    if ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0)) return CANON_NAN;
    return b;
  endfunction

endpackage

@@ src/spm_dly.sv @@
// Fixed-length delay line for aligning operands in the pipeline.
// Depends on nothing.
module spm_dly #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
  end

  assign q = taps[DEPTH-1];

endmodule

@@ src/spm_fmul.sv @@
// Single-precision multiplier, four stages, round to nearest even.
// Depends on spm_pkg.
module spm_fmul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  spm_pkg::fp_unp_t   ua, ub;
  logic [47:0]        prod;
  logic signed [11:0] e2, e3;
  spm_pkg::fp_flag_t  f2, f3;
  logic [26:0]        sig3;

  always_ff @(posedge clk) begin
    ua <= spm_pkg::fp_unpack(a);
    ub <= spm_pkg::fp_unpack(b);

    prod    <= ua.m * ub.m;
    e2      <= ua.e + ub.e - 12'sd127;
    f2.sgn  <= ua.sgn ^ ub.sgn;
    f2.nan  <= ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    f2.inf  <= ua.inf | ub.inf;
    f2.zero <= ua.zero | ub.zero;

    f3 <= f2;
    if (prod[47]) begin
      sig3 <= {prod[47:22], prod[21] | (|prod[20:0])};
      e3   <= e2 + 12'sd1;
    end else begin
      sig3 <= {prod[46:21], prod[20] | (|prod[19:0])};
      e3   <= e2;
    end

    if (f3.nan)       y <= spm_pkg::CANON_NAN;
    else if (f3.inf)  y <= {f3.sgn, 8'hFF, 23'd0};
    else if (f3.zero) y <= {f3.sgn, 31'd0};
    else              y <= spm_pkg::fp_round(f3.sgn, e3, sig3);
  end

endmodule

@@ src/spm_fadd.sv @@
// Single-precision adder, four stages: swap, align/add, normalize, round.
// Depends on spm_pkg.
module spm_fadd (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  spm_pkg::fp_unp_t   ua, ub, big, sml;
  logic               a_big;
  logic signed [11:0] diff;
  logic [4:0]         dd;
  logic [58:0]        wide;
  logic [26:0]        al;
  logic [4:0]         lz;

  logic               sub1, zs1, nan1, inf1, infs1;
  logic signed [11:0] e1;
  logic [4:0]         d1;
  logic [23:0]        bm1, sm1;
  logic               s1;

  logic [27:0]        sum2;
  logic signed [11:0] e2, e3;
  spm_pkg::fp_flag_t  f2, f3;
  logic               zs2, infs2, zs3, infs3;
  logic [26:0]        sig3;
  logic               ze3;

  always_comb begin
    ua    = spm_pkg::fp_unpack(a);
    ub    = spm_pkg::fp_unpack(b);
    a_big = (ua.e > ub.e) || ((ua.e == ub.e) && (ua.m >= ub.m));
    big   = a_big ? ua : ub;
    sml   = a_big ? ub : ua;
    diff  = big.e - sml.e;
    dd    = (diff > 12'sd31) ? 5'd31 : diff[4:0];
    wide  = {sm1, 3'd0, 32'd0} >> d1;
    al    = {wide[58:33], wide[32] | (|wide[31:0])};
    lz    = spm_pkg::lzc27(sum2[26:0]);
  end

  always_ff @(posedge clk) begin
    bm1   <= big.m;
    sm1   <= sml.m;
    e1    <= big.e;
    s1    <= big.sgn;
    d1    <= dd;
    sub1  <= ua.sgn ^ ub.sgn;
    zs1   <= ua.sgn & ub.sgn;
    nan1  <= ua.nan | ub.nan | (ua.inf & ub.inf & (ua.sgn ^ ub.sgn));
    inf1  <= ua.inf | ub.inf;
    infs1 <= ua.inf ? ua.sgn : ub.sgn;

    sum2    <= sub1 ? ({1'b0, bm1, 3'd0} - {1'b0, al}) : ({1'b0, bm1, 3'd0} + {1'b0, al});
    e2      <= e1;
    f2.sgn  <= s1;
    f2.nan  <= nan1;
    f2.inf  <= inf1;
    f2.zero <= 1'b0;
    zs2     <= zs1;
    infs2   <= infs1;

    f3    <= f2;
    zs3   <= zs2;
    infs3 <= infs2;
    ze3   <= (sum2 == 28'd0);
    if (sum2[27]) begin
      sig3 <= {sum2[27:2], sum2[1] | sum2[0]};
      e3   <= e2 + 12'sd1;
    end else begin
      sig3 <= sum2[26:0] << lz;
      e3   <= e2 - $signed({7'd0, lz});
    end

    if (f3.nan)      y <= spm_pkg::CANON_NAN;
    else if (f3.inf) y <= {infs3, 8'hFF, 23'd0};
    else if (ze3)    y <= {zs3, 31'd0};
    else             y <= spm_pkg::fp_round(f3.sgn, e3, sig3);
  end

endmodule

@@ src/spm_frcp.sv @@
// Pipelined reciprocal: one restoring division step per stage, then rounding.
// Depends on spm_pkg.
module spm_frcp (
  input  logic        clk,
  input  logic [31:0] a,
  output logic [31:0] y
);

  localparam int NDIV = 28;

  spm_pkg::fp_unp_t   u;
  logic [24:0]        rem_s [NDIV+1];
  logic [27:0]        q_s   [NDIV+1];
  logic [23:0]        md_s  [NDIV+1];
  logic signed [11:0] e_s   [NDIV+1];
  spm_pkg::fp_flag_t  f_s   [NDIV+1];
  logic [27:0]        qf;
  logic               st;

  assign u = spm_pkg::fp_unpack(a);

  always_ff @(posedge clk) begin
    rem_s[0]    <= 25'h080_0000;
    q_s[0]      <= 28'd0;
    md_s[0]     <= u.m;
    e_s[0]      <= u.e;
    f_s[0].sgn  <= u.sgn;
    f_s[0].nan  <= u.nan;
    f_s[0].inf  <= u.inf;
    f_s[0].zero <= u.zero;
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic        ge;
    logic [24:0] df;
    assign ge = rem_s[i] >= {1'b0, md_s[i]};
    assign df = ge ? (rem_s[i] - {1'b0, md_s[i]}) : rem_s[i];
    always_ff @(posedge clk) begin
      rem_s[i+1] <= {df[23:0], 1'b0};
      q_s[i+1]   <= {q_s[i][26:0], ge};
      md_s[i+1]  <= md_s[i];
      e_s[i+1]   <= e_s[i];
      f_s[i+1]   <= f_s[i];
    end
  end

  assign qf = q_s[NDIV];
  assign st = (rem_s[NDIV] != 25'd0);

  always_ff @(posedge clk) begin
    if (f_s[NDIV].nan)       y <= spm_pkg::CANON_NAN;
    else if (f_s[NDIV].zero) y <= {f_s[NDIV].sgn, 8'hFF, 23'd0};
    else if (f_s[NDIV].inf)  y <= {f_s[NDIV].sgn, 31'd0};
    else if (qf[27])         // divisor mantissa exactly one
      y <= spm_pkg::fp_round(f_s[NDIV].sgn, 12'sd254 - e_s[NDIV],
                             {qf[27:2], qf[1] | qf[0] | st});
    else
      y <= spm_pkg::fp_round(f_s[NDIV].sgn, 12'sd253 - e_s[NDIV], {qf[26:1], qf[0] | st});
  end

endmodule

@@ src/spm_fsqrt.sv @@
// Pipelined square root: one root digit per stage, then rounding.
// Depends on spm_pkg.
module spm_fsqrt (
  input  logic        clk,
  input  logic [31:0] a,
  output logic [31:0] y
);

  localparam int NSTEP = 27;

  spm_pkg::fp_unp_t   u;
  logic signed [11:0] ue, ueh;
  logic [24:0]        m2;

  logic [53:0]        rad_s  [NSTEP+1];
  logic [28:0]        rem_s  [NSTEP+1];
  logic [26:0]        root_s [NSTEP+1];
  logic signed [11:0] e_s    [NSTEP+1];
  spm_pkg::fp_flag_t  f_s    [NSTEP+1];
  logic               st;

  always_comb begin
    u   = spm_pkg::fp_unpack(a);
    ue  = u.e - 12'sd127;
    m2  = ue[0] ? {u.m, 1'b0} : {1'b0, u.m};
    ueh = (ue[0] ? (ue - 12'sd1) : ue) >>> 1;
  end

  always_ff @(posedge clk) begin
    rad_s[0]    <= {m2, 29'd0};
    rem_s[0]    <= 29'd0;
    root_s[0]   <= 27'd0;
    e_s[0]      <= ueh + 12'sd127;
    f_s[0].sgn  <= u.sgn;
    f_s[0].nan  <= u.nan | (u.sgn & ~u.zero);
    f_s[0].inf  <= u.inf;
    f_s[0].zero <= u.zero;
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_root
    logic [28:0] r4, trial;
    logic        ge;
    assign r4    = {rem_s[i][26:0], rad_s[i][53:52]};
    assign trial = {root_s[i], 2'b01};
    assign ge    = r4 >= trial;
    always_ff @(posedge clk) begin
      rad_s[i+1]  <= {rad_s[i][51:0], 2'b00};
      rem_s[i+1]  <= ge ? (r4 - trial) : r4;
      root_s[i+1] <= {root_s[i][25:0], ge};
      e_s[i+1]    <= e_s[i];
      f_s[i+1]    <= f_s[i];
    end
  end

  assign st = (rem_s[NSTEP] != 29'd0);

  always_ff @(posedge clk) begin
    if (f_s[NSTEP].nan)       y <= spm_pkg::CANON_NAN;
    else if (f_s[NSTEP].zero) y <= {f_s[NSTEP].sgn, 31'd0};
    else if (f_s[NSTEP].inf)  y <= {1'b0, 8'hFF, 23'd0};
    else
      y <= spm_pkg::fp_round(1'b0, e_s[NSTEP],
                             {root_s[NSTEP][26:1], root_s[NSTEP][0] | st});
  end

endmodule

@@ src/softened_point_mass_potential_unit.sv @@
// Top level of the softened point-mass potential unit: config registers,
// operand schedule and result select. Depends on spm_pkg and all spm_* units.
//
//  channel   signals                                      direction
//  command   start, busy, radius_sq                       in (busy out)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data    in (cfg_ready out)
//  result    done, pot_term, force_factor                 out
//
// One transaction is taken every cycle while busy is low. The depth is set by
// the reciprocal (30 stages: input, divide steps, rounding) and the square root
// (29 stages: input, root digits, rounding) in series with the multiply/add
// chain of the third-order kernel. busy is high only during reset. Reset
// loads the config defaults and clears the valid line; results are never held.
module softened_point_mass_potential_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] radius_sq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [31:0] pot_term,
  output logic [31:0] force_factor
);

  localparam int LATENCY = 112;

  logic [31:0] mass_term, scale_radius;
  logic [1:0]  kernel_order;
  logic        accept;
  logic [LATENCY-2:0] vld;

  logic        mass_nan, mass_neg;
  logic [31:0] g;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_term    <= 32'h3F80_0000;
      scale_radius <= 32'h3F80_0000;
      kernel_order <= spm_pkg::KORD_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spm_pkg::REG_MASS:   mass_term    <= cfg_data;
        spm_pkg::REG_RADIUS: scale_radius <= cfg_data;
        spm_pkg::REG_KERNEL: kernel_order <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // g = -|GM|; -0 compares not below zero, so it flips to +0
  assign mass_nan = (mass_term[30:23] == 8'hFF) && (mass_term[22:0] != 23'd0);
  assign mass_neg = mass_term[31] && (mass_term[30:0] != 31'd0) && !mass_nan;
  assign g        = mass_neg ? mass_term : {~mass_term[31], mass_term[30:0]};

  // signal suffix = cycle at which the value is valid, item presented at 0
  logic [31:0] aq_4, rq_4, den_8, hq_8, qq_12, x_38, sx_67;
  logic [31:0] x3_42, x5_42, x7_42, x_71, x_83, x3_75, x5_79, x7_83;
  logic [31:0] d0_71, d1_75, d2_79, d3_83, d4_87;
  logic [31:0] hq_75, hq_79, hq_83, hq_87, hq_91, hq_99, hq_103, qq_91, qq_95;
  logic [31:0] d0_79, d0_91, d0_103, d0_111, d1_83, d1_87, d1_95, d1_107, d1_111;
  logic [31:0] d2_87, d2_99, d3_91;
  logic [31:0] k1t_79, k1d0_83, k1u_83, k1v_87, k1d1_91;
  logic [31:0] k2a_83, k2b_87, k2c_91, k2d0_95, k2e_87, k2f_91, k2g_95, k2d1_99;
  logic [31:0] k3c_95, k3d_99, k3e_103, k3d0_107, k3f_91, k3g_95, k3h_99, k3i_103;
  logic [31:0] k3j_107, k3d1_111;
  logic [31:0] k1d0_111, k1d1_111, k2d0_111, k2d1_111, k3d0_111;

  spm_fmul  u_aq  (.clk, .a(scale_radius), .b(scale_radius), .y(aq_4));
  spm_dly #(.WIDTH(32), .DEPTH(4)) u_rq (.clk, .d(radius_sq), .q(rq_4));
  spm_fadd  u_den (.clk, .a(aq_4), .b(rq_4), .y(den_8));
  spm_fmul  u_hq  (.clk, .a(aq_4), .b(spm_pkg::F_HALF), .y(hq_8));
  spm_fmul  u_qq  (.clk, .a(hq_8), .b(spm_pkg::F_HALF), .y(qq_12));
  spm_frcp  u_rcp (.clk, .a(den_8), .y(x_38));
  spm_fsqrt u_sqt (.clk, .a(x_38), .y(sx_67));
  spm_fmul  u_x3  (.clk, .a(x_38), .b(spm_pkg::F_THREE), .y(x3_42));
  spm_fmul  u_x5  (.clk, .a(x_38), .b(spm_pkg::F_FIVE), .y(x5_42));
  spm_fmul  u_x7  (.clk, .a(x_38), .b(spm_pkg::F_SEVEN), .y(x7_42));

  spm_dly #(.WIDTH(32), .DEPTH(33)) u_x71  (.clk, .d(x_38), .q(x_71));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_x83  (.clk, .d(x_71), .q(x_83));
  spm_dly #(.WIDTH(32), .DEPTH(33)) u_x375 (.clk, .d(x3_42), .q(x3_75));
  spm_dly #(.WIDTH(32), .DEPTH(37)) u_x579 (.clk, .d(x5_42), .q(x5_79));
  spm_dly #(.WIDTH(32), .DEPTH(41)) u_x783 (.clk, .d(x7_42), .q(x7_83));

  spm_fmul u_d0 (.clk, .a(g), .b(sx_67), .y(d0_71));
  spm_fmul u_d1 (.clk, .a(d0_71), .b(x_71), .y(d1_75));
  spm_fmul u_d2 (.clk, .a(x3_75), .b(d1_75), .y(d2_79));
  spm_fmul u_d3 (.clk, .a(x5_79), .b(d2_79), .y(d3_83));
  spm_fmul u_d4 (.clk, .a(x7_83), .b(d3_83), .y(d4_87));

  spm_dly #(.WIDTH(32), .DEPTH(67)) u_hq75  (.clk, .d(hq_8), .q(hq_75));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_hq79  (.clk, .d(hq_75), .q(hq_79));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_hq83  (.clk, .d(hq_79), .q(hq_83));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_hq87  (.clk, .d(hq_83), .q(hq_87));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_hq91  (.clk, .d(hq_87), .q(hq_91));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_hq99  (.clk, .d(hq_91), .q(hq_99));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_hq103 (.clk, .d(hq_99), .q(hq_103));
  spm_dly #(.WIDTH(32), .DEPTH(79)) u_qq91  (.clk, .d(qq_12), .q(qq_91));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_qq95  (.clk, .d(qq_91), .q(qq_95));

  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d079  (.clk, .d(d0_71), .q(d0_79));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_d091  (.clk, .d(d0_79), .q(d0_91));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_d0103 (.clk, .d(d0_91), .q(d0_103));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d0111 (.clk, .d(d0_103), .q(d0_111));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d183  (.clk, .d(d1_75), .q(d1_83));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_d187  (.clk, .d(d1_83), .q(d1_87));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d195  (.clk, .d(d1_87), .q(d1_95));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_d1107 (.clk, .d(d1_95), .q(d1_107));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_d1111 (.clk, .d(d1_107), .q(d1_111));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d287  (.clk, .d(d2_79), .q(d2_87));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_d299  (.clk, .d(d2_87), .q(d2_99));
  spm_dly #(.WIDTH(32), .DEPTH(8))  u_d391  (.clk, .d(d3_83), .q(d3_91));

  // first order
  spm_fmul u_k1t  (.clk, .a(hq_75), .b(d1_75), .y(k1t_79));
  spm_fadd u_k1d0 (.clk, .a(d0_79), .b(k1t_79), .y(k1d0_83));
  spm_fmul u_k1u  (.clk, .a(k1t_79), .b(spm_pkg::F_THREE), .y(k1u_83));
  spm_fmul u_k1v  (.clk, .a(k1u_83), .b(x_83), .y(k1v_87));
  spm_fadd u_k1d1 (.clk, .a(d1_87), .b(k1v_87), .y(k1d1_91));

  // second order; d2 + h*d3 is shared with the third order
  spm_fmul u_k2a  (.clk, .a(hq_79), .b(d2_79), .y(k2a_83));
  spm_fadd u_k2b  (.clk, .a(d1_83), .b(k2a_83), .y(k2b_87));
  spm_fmul u_k2c  (.clk, .a(hq_87), .b(k2b_87), .y(k2c_91));
  spm_fadd u_k2d0 (.clk, .a(d0_91), .b(k2c_91), .y(k2d0_95));
  spm_fmul u_k2e  (.clk, .a(hq_83), .b(d3_83), .y(k2e_87));
  spm_fadd u_k2f  (.clk, .a(d2_87), .b(k2e_87), .y(k2f_91));
  spm_fmul u_k2g  (.clk, .a(hq_91), .b(k2f_91), .y(k2g_95));
  spm_fadd u_k2d1 (.clk, .a(d1_95), .b(k2g_95), .y(k2d1_99));

  // third order
  spm_fmul u_k3c  (.clk, .a(qq_91), .b(k2f_91), .y(k3c_95));
  spm_fadd u_k3d  (.clk, .a(d1_95), .b(k3c_95), .y(k3d_99));
  spm_fmul u_k3e  (.clk, .a(hq_99), .b(k3d_99), .y(k3e_103));
  spm_fadd u_k3d0 (.clk, .a(d0_103), .b(k3e_103), .y(k3d0_107));
  spm_fmul u_k3f  (.clk, .a(hq_87), .b(d4_87), .y(k3f_91));
  spm_fadd u_k3g  (.clk, .a(d3_91), .b(k3f_91), .y(k3g_95));
  spm_fmul u_k3h  (.clk, .a(qq_95), .b(k3g_95), .y(k3h_99));
  spm_fadd u_k3i  (.clk, .a(d2_99), .b(k3h_99), .y(k3i_103));
  spm_fmul u_k3j  (.clk, .a(hq_103), .b(k3i_103), .y(k3j_107));
  spm_fadd u_k3d1 (.clk, .a(d1_107), .b(k3j_107), .y(k3d1_111));

  spm_dly #(.WIDTH(32), .DEPTH(28)) u_o1 (.clk, .d(k1d0_83), .q(k1d0_111));
  spm_dly #(.WIDTH(32), .DEPTH(20)) u_o2 (.clk, .d(k1d1_91), .q(k1d1_111));
  spm_dly #(.WIDTH(32), .DEPTH(16)) u_o3 (.clk, .d(k2d0_95), .q(k2d0_111));
  spm_dly #(.WIDTH(32), .DEPTH(12)) u_o4 (.clk, .d(k2d1_99), .q(k2d1_111));
  spm_dly #(.WIDTH(32), .DEPTH(4))  u_o5 (.clk, .d(k3d0_107), .q(k3d0_111));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LATENCY-3:0], accept};
      done <= vld[LATENCY-2];
    end
    case (kernel_order)
      spm_pkg::KORD_ONE: begin
        pot_term     <= spm_pkg::fp_canon(k1d0_111);
        force_factor <= spm_pkg::fp_canon(k1d1_111);
      end
      spm_pkg::KORD_TWO: begin
        pot_term     <= spm_pkg::fp_canon(k2d0_111);
        force_factor <= spm_pkg::fp_canon(k2d1_111);
      end
      spm_pkg::KORD_THREE: begin
        pot_term     <= spm_pkg::fp_canon(k3d0_111);
        force_factor <= spm_pkg::fp_canon(k3d1_111);
      end
      default: begin
        pot_term     <= spm_pkg::fp_canon(d0_111);
        force_factor <= spm_pkg::fp_canon(d1_111);
      end
    endcase
  end

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    (done && (pot_term[30:23] == 8'hFF) && (pot_term[22:0] != 23'd0))
      |-> (pot_term == spm_pkg::CANON_NAN))
    else $error("non-canonical NaN on pot_term");

  a_kernel_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == spm_pkg::REG_KERNEL))
      |=> (kernel_order == $past(cfg_data[1:0])))
    else $error("kernel order write lost");

endmodule
